// ===== hw/rtl/okm_pkg.sv =====
// Shared constants, types and codes for the online k-means cluster assignment block.
`timescale 1ns / 1ps

package okm_pkg;

    // Array sizes. DIMS is fixed at four by the feature fields of the input word.
    localparam int CLUSTERS     = 8;
    localparam int DIMS         = 4;
    localparam int FEATURE_BITS = 16;

    // Derived widths.
    localparam int IDX_W     = $clog2(CLUSTERS);
    localparam int CNT_W     = $clog2(CLUSTERS + 1);
    localparam int TERM_W    = 2 * FEATURE_BITS;
    localparam int DIST_W    = TERM_W + $clog2(DIMS);
    localparam int OUT_IDX_W = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int METRIC_W   = 1;
    localparam int CLCNT_W    = 4;
    localparam int CMP_W      = (CNT_W > CLCNT_W) ? CNT_W : CLCNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_METRIC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT   = 1'b1;

    localparam logic [METRIC_W-1:0] METRIC_EUCLID    = 1'b0;
    localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 1'b1;

    localparam logic [CLCNT_W-1:0] CLCNT_RESET = 4'd8;

    localparam logic FUNC_TRAIN   = 1'b0;
    localparam logic FUNC_PREDICT = 1'b1;

    typedef logic signed [FEATURE_BITS-1:0] feat_t;
    typedef feat_t [DIMS-1:0] feat_vec_t;

    // Running best match that travels along the chain of cells.
    typedef struct packed {
        logic              valid;
        logic              has;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] score;
    } best_t;

    // Centroid write command broadcast to the cells.
    typedef struct packed {
        logic             en;
        logic             seed;
        logic [IDX_W-1:0] idx;
    } wr_t;

endpackage

// ===== hw/rtl/okm_ifs.sv =====
// Valid/ready channel interfaces for observation words and result words.
`timescale 1ns / 1ps

interface okm_obs_if import okm_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  func;
    feat_t feature_0;
    feat_t feature_1;
    feat_t feature_2;
    feat_t feature_3;

    modport source (output valid, func, feature_0, feature_1, feature_2, feature_3,
                    input ready);
    modport sink   (input valid, func, feature_0, feature_1, feature_2, feature_3,
                    output ready);
endinterface

interface okm_res_if import okm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] cluster_index;
    logic                 was_seed;

    modport source (output valid, cluster_index, was_seed, input ready);
    modport sink   (input valid, cluster_index, was_seed, output ready);
endinterface

// ===== hw/rtl/okm_cell.sv =====
// One cell of the search chain: holds one centroid and scores the vector passing by.
`timescale 1ns / 1ps

module okm_cell import okm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    cell_idx,
    input  logic [METRIC_W-1:0] metric,
    input  logic [CNT_W-1:0]    active_n,
    input  feat_vec_t           vec_in,
    output feat_vec_t           vec_out,
    input  best_t               best_in,
    output best_t               best_out,
    input  wr_t                 wr,
    input  feat_vec_t           wr_vec
);

    feat_vec_t               cent_reg;
    feat_vec_t               vec_reg;
    logic [TERM_W-1:0]       term_next [DIMS];
    logic [TERM_W-1:0]       term_reg  [DIMS];
    logic [DIST_W-1:0]       score;
    logic                    active;
    logic                    take;
    best_t                   best_next;
    best_t                   best_reg;
    feat_vec_t               mid;

    // Per-feature distance terms against the vector arriving this cycle.
    always_comb
    begin
        logic [FEATURE_BITS:0]   diff;
        logic [FEATURE_BITS:0]   neg;
        logic [FEATURE_BITS-1:0] mag;
        for (int d = 0; d < DIMS; d++)
        begin
            diff = {vec_in[d][FEATURE_BITS-1], vec_in[d]}
                 - {cent_reg[d][FEATURE_BITS-1], cent_reg[d]};
            neg  = '0 - diff;
            mag  = diff[FEATURE_BITS] ? neg[FEATURE_BITS-1:0] : diff[FEATURE_BITS-1:0];
            if (metric == METRIC_MANHATTAN)
                term_next[d] = TERM_W'(mag);
            else
                term_next[d] = mag * mag;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_in;
        for (int d = 0; d < DIMS; d++)
            term_reg[d] <= term_next[d];
    end

    assign vec_out = vec_reg;

    // The running best reaches this cell in the cycle after the vector did.
    always_comb
    begin
        score = '0;
        for (int d = 0; d < DIMS; d++)
            score = score + DIST_W'(term_reg[d]);
    end

    assign active = CNT_W'(cell_idx) < active_n;
    // A strict compare keeps the lower index on a tie.
    assign take   = best_in.valid && active && (!best_in.has || score < best_in.score);

    always_comb
    begin
        best_next = best_in;
        if (take)
        begin
            best_next.has   = 1'b1;
            best_next.idx   = cell_idx;
            best_next.score = score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_reg <= '0;
        else
            best_reg <= best_next;
    end

    assign best_out = best_reg;

    // Midpoint (c + x) >> 1 with an arithmetic shift: drop the low bit of the wide sum.
    always_comb
    begin
        logic [FEATURE_BITS:0] sum;
        for (int d = 0; d < DIMS; d++)
        begin
            sum    = {wr_vec[d][FEATURE_BITS-1], wr_vec[d]}
                   + {cent_reg[d][FEATURE_BITS-1], cent_reg[d]};
            mid[d] = sum[FEATURE_BITS:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == cell_idx)
            cent_reg <= wr.seed ? wr_vec : mid;
    end

endmodule

// ===== hw/rtl/online_kmeans_cluster_assign_core.sv =====
// Top level of the online k-means cluster assignment block.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake          Word
//  obs       in         obs.valid/ready    func, feature_0 .. feature_3
//  res       out        res.valid/ready    cluster_index, was_seed
//  cfg       in         cfg_write          cfg_index, cfg_data (no back-pressure)
//
//  A seeding word passes through the decide and finish states before the next
//  acceptance; an assigning or predicting word also searches, for as long as
//  the running best match takes to walk the chain of cells one cell a cycle.
//  Reset clears the seeded count, the configuration and all control state; the
//  centroids hold nothing until seeded. A stalled result waits in the output
//  register while the next word is taken in; a second finished result waits
//  until that register is free.

module online_kmeans_cluster_assign_core import okm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    okm_obs_if.sink               obs,
    okm_res_if.source             res,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [METRIC_W-1:0]    metric_reg;
    logic [CLCNT_W-1:0]     clcnt_reg;
    logic [CNT_W-1:0]       seeded_reg;
    logic [CNT_W-1:0]       k;
    logic [CNT_W-1:0]       active_n;
    logic                   func_reg;
    feat_vec_t              x_reg;
    logic                   start_reg;
    wr_t                    wr_reg;
    logic [IDX_W-1:0]       res_idx_reg;
    logic                   res_seed_reg;
    logic                   out_valid_reg;
    logic [OUT_IDX_W-1:0]   out_idx_reg;
    logic                   out_seed_reg;
    feat_vec_t              vec_chain  [CLUSTERS+1];
    best_t                  best_chain [CLUSTERS+1];
    best_t                  final_best;

    // Config registers: user writes only while the block is idle; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_EUCLID;
            clcnt_reg  <= CLCNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DISTANCE_METRIC: metric_reg <= cfg_data[METRIC_W-1:0];
                REG_CLUSTER_COUNT:   clcnt_reg  <= cfg_data[CLCNT_W-1:0];
            endcase
        end
    end

    // Clusters in use: a count of zero behaves as one, and anything above the
    // number of cells behaves as the number of cells.
    always_comb
    begin
        if (clcnt_reg == '0)
            k = CNT_W'(1);
        else if (CMP_W'(clcnt_reg) > CMP_W'(CLUSTERS))
            k = CNT_W'(CLUSTERS);
        else
            k = CNT_W'(clcnt_reg);
    end

    // Only centroids that were seeded and are in use take part in a search.
    assign active_n = (seeded_reg < k) ? seeded_reg : k;

    // Capture of the accepted word; it stays put until the next acceptance, so
    // the cells may read it for the whole search and for the centroid write.
    always_ff @(posedge clk)
    begin
        if (obs.valid && obs.ready)
        begin
            func_reg <= obs.func;
            x_reg[0] <= obs.feature_0;
            x_reg[1] <= obs.feature_1;
            x_reg[2] <= obs.feature_2;
            x_reg[3] <= obs.feature_3;
        end
    end

    assign obs.ready = (state_reg == ST_IDLE);

    // Head of the chain: the vector enters cell 0 straight from the capture
    // register, and an empty best match is launched in the cycle after the vector
    // settles, so every cell scores the right vector when the token arrives.
    assign vec_chain[0]  = x_reg;
    always_comb
    begin
        best_chain[0]       = '0;
        best_chain[0].valid = start_reg;
    end

    for (genvar g = 0; g < CLUSTERS; g++)
    begin : g_cell
        okm_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .metric   (metric_reg),
            .active_n (active_n),
            .vec_in   (vec_chain[g]),
            .vec_out  (vec_chain[g+1]),
            .best_in  (best_chain[g]),
            .best_out (best_chain[g+1]),
            .wr       (wr_reg),
            .wr_vec   (x_reg)
        );
    end

    assign final_best = best_chain[CLUSTERS];

    // Sequencer. A seeding word is settled in the decide state; any other word
    // launches a search and waits for the best match to leave the last cell.
    // Any centroid write is issued on entry to the finish state, one cycle only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= '0;
            start_reg     <= 1'b0;
            wr_reg        <= '0;
            res_idx_reg   <= '0;
            res_seed_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_seed_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            wr_reg.en <= 1'b0;
            if (res.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (obs.valid)
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (func_reg == FUNC_TRAIN && seeded_reg < k)
                    begin
                        wr_reg.en    <= 1'b1;
                        wr_reg.seed  <= 1'b1;
                        wr_reg.idx   <= seeded_reg[IDX_W-1:0];
                        seeded_reg   <= seeded_reg + CNT_W'(1);
                        res_idx_reg  <= seeded_reg[IDX_W-1:0];
                        res_seed_reg <= 1'b1;
                        state_reg    <= ST_FINISH;
                    end
                    else
                    begin
                        start_reg <= 1'b1;
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (final_best.valid)
                    begin
                        // With no centroid in use the token arrives empty and
                        // reports cluster 0 with no update.
                        wr_reg.en    <= (func_reg == FUNC_TRAIN) && final_best.has;
                        wr_reg.seed  <= 1'b0;
                        wr_reg.idx   <= final_best.idx;
                        res_idx_reg  <= final_best.idx;
                        res_seed_reg <= 1'b0;
                        state_reg    <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= OUT_IDX_W'(res_idx_reg);
                        out_seed_reg  <= res_seed_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.cluster_index = out_idx_reg;
    assign res.was_seed      = out_seed_reg;

`ifndef NO_ASSERTIONS
    // The seeded count never runs past the number of cells.
    a_seeded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg <= CNT_W'(CLUSTERS))
        else $error("seeded count beyond the number of cells");

    // A best match only leaves the chain while a search is under way.
    a_chain_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        final_best.valid |-> state_reg == ST_SEARCH)
        else $error("best match left the chain outside a search");

    // A centroid write is issued exactly on entry to the finish state.
    a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg.en |-> state_reg == ST_FINISH && $past(state_reg) != ST_FINISH)
        else $error("centroid write outside the first finish cycle");

    // A launched search always has its word in the capture register unchanged.
    a_start_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> state_reg == ST_SEARCH && $stable(x_reg))
        else $error("search launched without a settled vector");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the online k-means cluster assignment core.
`timescale 1ns / 1ps

module tb_top;
    import okm_pkg::*;

    // The run is cut short at this many cycles. The slowest correct run is
    // about 400 words, each passing through the core plus stalls on both
    // channels.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_PHASES = 9;
    localparam int WORDS_PER_PHASE = 44;

    // One observation word as it travels on the input channel.
    typedef struct packed {
        logic      func;
        feat_vec_t feat;
    } obs_word_t;

    // One result word as the core should produce it.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] cluster_index;
        logic                 was_seed;
    } assignment_t;

    // The scoreboard keeps its own copy of the centroids, the seeded count and
    // both registers. Every accepted observation word is run through this copy
    // to give the result word that the core owes, and the result words that
    // the core delivers are matched against those, oldest first.
    class cluster_assign_scoreboard;
        feat_t                centroid [CLUSTERS][DIMS];
        int unsigned          seeded;
        logic [METRIC_W-1:0]  metric;
        logic [CLCNT_W-1:0]   cluster_count;
        assignment_t          expected_assignments[$];
        int unsigned          mismatches;

        function new();
            seeded        = 0;
            metric        = METRIC_EUCLID;
            cluster_count = CLCNT_RESET;
            mismatches    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == REG_DISTANCE_METRIC)
                metric = data[METRIC_W-1:0];
            else if (index == REG_CLUSTER_COUNT)
                cluster_count = data[CLCNT_W-1:0];
        endfunction

        // Exact distance from x to centroid c under the current metric.
        function longint unsigned distance(feat_t x [DIMS], int unsigned c);
            longint            diff;
            longint unsigned   mag;
            longint unsigned   sum;
            sum = 0;
            for (int d = 0; d < DIMS; d++)
            begin
                diff = longint'(x[d]) - longint'(centroid[c][d]);
                mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
                sum += (metric == METRIC_MANHATTAN) ? mag : mag * mag;
            end
            return sum;
        endfunction

        function void note_observation(obs_word_t w);
            feat_t             x [DIMS];
            int unsigned       k;
            int unsigned       n;
            int unsigned       best;
            longint unsigned   best_dist;
            longint unsigned   cand_dist;
            int                total;
            assignment_t       a;

            for (int d = 0; d < DIMS; d++)
                x[d] = w.feat[d];

            // A count of zero behaves as one, anything above the array size as
            // the array size.
            k = (cluster_count == 0) ? 1 : cluster_count;
            if (k > CLUSTERS)
                k = CLUSTERS;
            n = (seeded < k) ? seeded : k;

            if (w.func == FUNC_TRAIN && seeded < k)
            begin
                for (int d = 0; d < DIMS; d++)
                    centroid[seeded][d] = x[d];
                a.cluster_index = seeded[OUT_IDX_W-1:0];
                a.was_seed      = 1'b1;
                seeded++;
            end
            else
            begin
                // Strictly smaller wins, so the lowest index keeps a tie.
                best      = 0;
                best_dist = 0;
                for (int unsigned c = 0; c < n; c++)
                begin
                    cand_dist = distance(x, c);
                    if (c == 0 || cand_dist < best_dist)
                    begin
                        best      = c;
                        best_dist = cand_dist;
                    end
                end
                // The winner moves to the midpoint, rounded towards minus
                // infinity by the arithmetic shift.
                if (w.func == FUNC_TRAIN && n > 0)
                begin
                    for (int d = 0; d < DIMS; d++)
                    begin
                        total = int'(centroid[best][d]) + int'(x[d]);
                        centroid[best][d] = feat_t'(total >>> 1);
                    end
                end
                a.cluster_index = best[OUT_IDX_W-1:0];
                a.was_seed      = 1'b0;
            end
            expected_assignments = {expected_assignments, a};
        endfunction

        function void check_result(logic [OUT_IDX_W-1:0] cluster_index, logic was_seed);
            assignment_t a;
            if (expected_assignments.size() == 0)
            begin
                $error("result word with none expected: cluster_index %0d was_seed %0b",
                       cluster_index, was_seed);
                mismatches++;
                return;
            end
            a = expected_assignments.pop_front();
            if (cluster_index !== a.cluster_index)
            begin
                $error("cluster_index expected %0d actual %0d", a.cluster_index, cluster_index);
                mismatches++;
            end
            if (was_seed !== a.was_seed)
            begin
                $error("was_seed expected %0b actual %0b", a.was_seed, was_seed);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_assignments.size();
        endfunction

        function bit clean();
            return mismatches == 0 && expected_assignments.size() == 0;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    okm_obs_if obs_ch ();
    okm_res_if res_ch ();

    cluster_assign_scoreboard sb = new();

    // Words waiting to be offered, and the idling rates of the two sides in
    // percent of cycles.
    obs_word_t   stimulus_q[$];
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned cycle_count;

    // Centres around which most random observations fall, so that the
    // clusters stay apart and assignments are not decided by noise alone.
    int hub [CLUSTERS][DIMS];

    online_kmeans_cluster_assign_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .obs       (obs_ch),
        .res       (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at the current rate; it changes ready only at the
    // falling edge, so the core sees a steady value at every rising edge.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Result words are taken at the rising edge at which valid and ready meet.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_result(res_ch.cluster_index, res_ch.was_seed);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Writes one register. The enable is dropped once the write is taken and
    // the task returns on a further falling edge, so two writes in a row
    // never lower and raise the enable in the same time step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(index, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_word(input logic func, input int f0, input int f1,
                              input int f2, input int f3);
        obs_word_t w;
        w.func    = func;
        w.feat[0] = feat_t'(f0);
        w.feat[1] = feat_t'(f1);
        w.feat[2] = feat_t'(f2);
        w.feat[3] = feat_t'(f3);
        stimulus_q = {stimulus_q, w};
    endtask

    // Offers every queued word in turn and then waits until the scoreboard
    // has seen all of their results, which leaves the core idle. Called and
    // left at a falling edge. Valid stays high from one word to the next
    // when the sender does not idle in between.
    task automatic run_words();
        obs_word_t w;
        while (stimulus_q.size() > 0)
        begin
            w = stimulus_q.pop_front();
            while ($urandom_range(99) < src_idle_pct)
            begin
                obs_ch.valid <= 1'b0;
                @(negedge clk);
            end
            obs_ch.valid     <= 1'b1;
            obs_ch.func      <= w.func;
            obs_ch.feature_0 <= w.feat[0];
            obs_ch.feature_1 <= w.feat[1];
            obs_ch.feature_2 <= w.feat[2];
            obs_ch.feature_3 <= w.feat[3];
            @(posedge clk);
            while (obs_ch.ready !== 1'b1)
                @(posedge clk);
            sb.note_observation(w);
            @(negedge clk);
        end
        obs_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Most words lie near one of the centres, some are anywhere in the
    // feature range and some sit on the extremes of it.
    function automatic obs_word_t random_observation();
        obs_word_t w;
        int        pick;
        int        h;
        int        spread;
        int        v;
        w.func = ($urandom_range(99) < 25) ? FUNC_PREDICT : FUNC_TRAIN;
        pick   = $urandom_range(99);
        h      = $urandom_range(CLUSTERS - 1);
        spread = $urandom_range(1) ? 255 : 4095;
        for (int d = 0; d < DIMS; d++)
        begin
            if (pick < 70)
            begin
                v = hub[h][d] + int'($urandom_range(2 * spread)) - spread;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
            end
            else if (pick < 85)
                v = int'(feat_t'($urandom()));
            else
            begin
                case ($urandom_range(3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            w.feat[d] = feat_t'(v);
        end
        return w;
    endfunction

    initial
    begin
        logic [CLCNT_W-1:0] count_plan  [RANDOM_PHASES];
        logic [METRIC_W-1:0] metric_plan [RANDOM_PHASES];
        logic [CFG_DATA_W-1:0] data;

        count_plan  = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd9, 4'd2, 4'd8, 4'd12};
        metric_plan = '{METRIC_EUCLID, METRIC_MANHATTAN, METRIC_EUCLID,
                        METRIC_MANHATTAN, METRIC_MANHATTAN, METRIC_EUCLID,
                        METRIC_MANHATTAN, METRIC_EUCLID, METRIC_MANHATTAN};

        cycle_count      = 0;
        src_idle_pct     = 11;
        sink_idle_pct    = 71;
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = REG_DISTANCE_METRIC;
        cfg_data         = '0;
        obs_ch.valid     = 1'b0;
        obs_ch.func      = FUNC_TRAIN;
        obs_ch.feature_0 = '0;
        obs_ch.feature_1 = '0;
        obs_ch.feature_2 = '0;
        obs_ch.feature_3 = '0;

        for (int c = 0; c < CLUSTERS; c++)
            for (int d = 0; d < DIMS; d++)
                hub[c][d] = int'($urandom_range(60000)) - 30000;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A cluster count of zero behaves as one. Predicts before any seed
        // must give index zero, then the first train word seeds slot zero and
        // the next one is assigned there, with both feature extremes and a
        // midpoint that rounds down below zero.
        write_register(REG_CLUSTER_COUNT, 4'd0);
        write_register(REG_DISTANCE_METRIC, {3'b000, METRIC_MANHATTAN});
        queue_word(FUNC_PREDICT, 0, 0, 0, 0);
        queue_word(FUNC_PREDICT, 32767, -32768, -1, 1);
        queue_word(FUNC_TRAIN, -32768, 32767, 0, -1);
        queue_word(FUNC_TRAIN, 32767, -32768, 32767, -32768);
        queue_word(FUNC_PREDICT, 0, 0, 0, 0);
        run_words();

        // Raising the count lets the next train words seed the new slots.
        // The origin is then equally far from slots one and two, so the lower
        // index must win the tie.
        write_register(REG_CLUSTER_COUNT, 4'd3);
        write_register(REG_DISTANCE_METRIC, {3'b111, METRIC_EUCLID});
        queue_word(FUNC_TRAIN, 100, 0, 0, 0);
        queue_word(FUNC_TRAIN, -100, 0, 0, 0);
        queue_word(FUNC_PREDICT, 0, 0, 0, 0);
        queue_word(FUNC_TRAIN, 1, 0, 0, 0);
        run_words();

        // Counts above the array size behave as the full array, so the
        // remaining slots seed and then the largest distances are compared.
        write_register(REG_CLUSTER_COUNT, 4'd15);
        write_register(REG_DISTANCE_METRIC, {3'b101, METRIC_MANHATTAN});
        queue_word(FUNC_PREDICT, 0, 0, 0, 0);
        queue_word(FUNC_TRAIN, 1000, 1000, 1000, 1000);
        queue_word(FUNC_TRAIN, -1000, -1000, -1000, -1000);
        queue_word(FUNC_TRAIN, 32767, 32767, 32767, 32767);
        queue_word(FUNC_TRAIN, -32768, -32768, -32768, -32768);
        queue_word(FUNC_TRAIN, 0, 32767, -32768, 0);
        queue_word(FUNC_TRAIN, 32767, 32767, 32767, 32767);
        queue_word(FUNC_PREDICT, -32768, 32767, -32768, 32767);
        queue_word(FUNC_TRAIN, -32768, 32767, -32768, 32767);
        run_words();

        // Random part: nine settings of the two registers, three under each
        // idling pattern. The sender idles lightly and the receiver heavily
        // first, then the other way round, and at the end neither idles.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p / 3)
                0:
                begin
                    src_idle_pct  = 11;
                    sink_idle_pct = 71;
                end
                1:
                begin
                    src_idle_pct  = 71;
                    sink_idle_pct = 11;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            data = CFG_DATA_W'($urandom_range(15));
            data[METRIC_W-1:0] = metric_plan[p];
            write_register(REG_DISTANCE_METRIC, data);
            write_register(REG_CLUSTER_COUNT, count_plan[p]);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                stimulus_q = {stimulus_q, random_observation()};
            run_words();
        end

        // Everything has been answered; give the core time to show any stray
        // result word before the verdict.
        repeat (2 * CLUSTERS + 8) @(negedge clk);
        if (sb.clean())
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
